// ===== rtl/hsfd_pkg.sv =====
// Shared types, constants and the CRC-8 byte update for the humidity sensor frame decoder.
package hsfd_pkg;

  // CRC-8 as used by the sensor: polynomial 0x31, seed 0xFF, MSB first, no final XOR.
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Conversion constants: full scale of a raw word and the scaled spans.
  localparam logic [15:0] FULL_SCALE  = 16'hFFFF;
  localparam logic [14:0] TEMP_SPAN   = 15'd17500;
  localparam logic [13:0] HUM_SPAN    = 14'd10000;
  localparam logic [15:0] TEMP_OFFSET = 16'd4500;

  // Default depth of the frame queue between the front and the back.
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // Position of the next byte within a six-byte frame.
  typedef enum logic [5:0] {
    POS_T_HI  = 6'b000001,
    POS_T_LO  = 6'b000010,
    POS_T_CHK = 6'b000100,
    POS_H_HI  = 6'b001000,
    POS_H_LO  = 6'b010000,
    POS_H_CHK = 6'b100000
  } pos_t;

  // One complete frame, handed from the front to the back.
  typedef struct packed {
    logic [15:0] temperature_raw;
    logic [15:0] humidity_raw;
    logic        status;
  } frame_t;

  // Push side of the frame queue as seen by the front.
  typedef struct packed {
    logic   push;
    frame_t frame;
  } push_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] r;
    r = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (r[7]) begin
        r = {r[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[6:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/humidity_sensor_frame_decoder.sv =====
// Top level of the humidity sensor frame decoder: front, frame queue and conversion back end.
//
// The input stream carries the six bytes of one measurement frame, one item per byte:
// temperature high, temperature low, temperature CRC, humidity high, humidity low, humidity
// CRC. tuser marks a byte as the first of a new frame and drops any partial frame. Without
// it, frames follow one another with no gap or marker. Each CRC is CRC-8 (polynomial 0x31,
// seed 0xFF) over the two word bytes before it.
// After the sixth byte the output stream carries one item: both converted values, both raw
// words, and in tuser a flag that is set when either CRC byte did not match. A mismatch
// still delivers the converted values.
// Throughput is one byte per cycle while the queue is not full; the front computes the next
// position and CRC combinationally and registers them on each accepted byte. A result
// passes through the frame queue, the product stage and the output register, in that order.
// When the receiver stalls, the result holds in the output register, one more waits in
// the product stage and the frame queue takes up to QUEUE_DEPTH further frames. Input
// tready drops only once the queue is full, with QUEUE_DEPTH frames behind those two.
// Reset clears the frame position, the CRC, the queue and all valid flags at once.
module humidity_sensor_frame_decoder #(
  parameter int QUEUE_DEPTH = hsfd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] frame_restart
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [14:0] temperature_centi, [28:15] humidity_centi,
                                      // [44:29] temperature_raw, [60:45] humidity_raw,
                                      // [63:61] zero
  output logic        m_axis_tuser    // [0] status
);

  hsfd_pkg::push_t  push;
  hsfd_pkg::frame_t q_frame;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;
  logic signed [14:0] temperature_centi;
  logic [13:0]      humidity_centi;
  logic [15:0]      temperature_raw;
  logic [15:0]      humidity_raw;
  logic             status;

  hsfd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .rx_byte       (s_axis_tdata),
    .frame_restart (s_axis_tuser),
    .queue_full    (q_full),
    .push_out      (push)
  );

  hsfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_in   (push),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_frame (q_frame)
  );

  hsfd_back u_back (
    .clk               (clk),
    .rst               (rst),
    .frame_valid       (q_valid),
    .frame_pop         (q_pop),
    .frame             (q_frame),
    .out_valid         (m_axis_tvalid),
    .out_ready         (m_axis_tready),
    .temperature_centi (temperature_centi),
    .humidity_centi    (humidity_centi),
    .temperature_raw   (temperature_raw),
    .humidity_raw      (humidity_raw),
    .status            (status)
  );

  // Fields are packed from the lowest bit up, padded with zeros to a whole byte.
  assign m_axis_tdata = {3'b000, humidity_raw, temperature_raw, humidity_centi,
                         temperature_centi};
  assign m_axis_tuser = status;

endmodule

// ===== rtl/hsfd_front.sv =====
// Front part: takes frame bytes, tracks the frame position, checks both CRCs, emits frames.
module hsfd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          rx_byte,
  input  logic                frame_restart,
  input  logic                queue_full,
  output hsfd_pkg::push_t     push_out
);

  hsfd_pkg::pos_t pos;
  hsfd_pkg::pos_t pos_next;
  hsfd_pkg::pos_t pos_eff;
  logic [7:0]     running_check;
  logic [7:0]     running_check_next;
  logic [15:0]    temperature_word;
  logic [15:0]    temperature_word_next;
  logic           temperature_check_good;
  logic           temperature_check_good_next;
  logic [15:0]    humidity_word;
  logic [15:0]    humidity_word_next;
  logic           accept;
  logic           hum_good;

  assign in_ready = !queue_full;
  assign accept   = in_valid && !queue_full;
  assign pos_eff  = frame_restart ? hsfd_pkg::POS_T_HI : pos;
  assign hum_good = (running_check == rx_byte);

  always_comb begin
    pos_next                    = pos;
    running_check_next          = running_check;
    temperature_word_next       = temperature_word;
    temperature_check_good_next = temperature_check_good;
    humidity_word_next          = humidity_word;
    unique case (pos_eff)
      hsfd_pkg::POS_T_LO: begin
        running_check_next    = hsfd_pkg::crc8_byte(running_check, rx_byte);
        temperature_word_next = {temperature_word[15:8], rx_byte};
        pos_next              = hsfd_pkg::POS_T_CHK;
      end
      hsfd_pkg::POS_T_CHK: begin
        temperature_check_good_next = (running_check == rx_byte);
        running_check_next          = hsfd_pkg::CRC_INIT;
        pos_next                    = hsfd_pkg::POS_H_HI;
      end
      hsfd_pkg::POS_H_HI: begin
        running_check_next = hsfd_pkg::crc8_byte(hsfd_pkg::CRC_INIT, rx_byte);
        humidity_word_next = {rx_byte, 8'h00};
        pos_next           = hsfd_pkg::POS_H_LO;
      end
      hsfd_pkg::POS_H_LO: begin
        running_check_next = hsfd_pkg::crc8_byte(running_check, rx_byte);
        humidity_word_next = {humidity_word[15:8], rx_byte};
        pos_next           = hsfd_pkg::POS_H_CHK;
      end
      hsfd_pkg::POS_H_CHK: begin
        running_check_next = hsfd_pkg::CRC_INIT;
        pos_next           = hsfd_pkg::POS_T_HI;
      end
      default: begin
        // First byte of a frame, and any position that does not decode.
        running_check_next    = hsfd_pkg::crc8_byte(hsfd_pkg::CRC_INIT, rx_byte);
        temperature_word_next = {rx_byte, 8'h00};
        pos_next              = hsfd_pkg::POS_T_LO;
      end
    endcase
  end

  always_comb begin
    push_out.push                  = accept && (pos_eff == hsfd_pkg::POS_H_CHK);
    push_out.frame.temperature_raw = temperature_word;
    push_out.frame.humidity_raw    = humidity_word;
    push_out.frame.status          = !(temperature_check_good && hum_good);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos                    <= hsfd_pkg::POS_T_HI;
      running_check          <= hsfd_pkg::CRC_INIT;
      temperature_word       <= '0;
      temperature_check_good <= 1'b0;
      humidity_word          <= '0;
    end else if (accept) begin
      pos                    <= pos_next;
      running_check          <= running_check_next;
      temperature_word       <= temperature_word_next;
      temperature_check_good <= temperature_check_good_next;
      humidity_word          <= humidity_word_next;
    end
  end

endmodule

// ===== rtl/hsfd_queue.sv =====
// Short frame queue that lets the front and the back stall independently.
module hsfd_queue #(
  parameter int DEPTH = hsfd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  hsfd_pkg::push_t  push_in,
  output logic             full,
  output logic             pop_valid,
  input  logic             pop,
  output hsfd_pkg::frame_t pop_frame
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  hsfd_pkg::frame_t entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == FULL_COUNT);
  assign pop_valid = (count != '0);
  assign do_push   = push_in.push && !full;
  assign do_pop    = pop && pop_valid;
  assign pop_frame = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_in.frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/hsfd_back.sv =====
// Back part: scales both raw words to centi units and holds the result for the receiver.
module hsfd_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  frame_valid,
  output logic                  frame_pop,
  input  hsfd_pkg::frame_t      frame,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [14:0]    temperature_centi,
  output logic [13:0]           humidity_centi,
  output logic [15:0]           temperature_raw,
  output logic [15:0]           humidity_raw,
  output logic                  status
);

  // Product stage.
  logic             s1_valid;
  logic [30:0]      t_prod;
  logic [29:0]      h_prod;
  hsfd_pkg::frame_t s1_frame;
  logic             s1_load;
  logic             out_load;

  // Division by 65535: q0 = p >> 16 leaves a remainder below twice the divisor.
  logic [14:0]      t_q0;
  logic [16:0]      t_rem;
  logic [14:0]      t_q;
  logic [13:0]      h_q0;
  logic [16:0]      h_rem;
  logic [13:0]      h_q;
  logic [15:0]      t_shift;

  assign out_load  = s1_valid && (!out_valid || out_ready);
  assign s1_load   = frame_valid && (!s1_valid || out_load);
  assign frame_pop = s1_load;

  assign t_q0    = t_prod[30:16];
  assign t_rem   = {1'b0, t_prod[15:0]} + {2'b00, t_q0};
  assign t_q     = (t_rem >= {1'b0, hsfd_pkg::FULL_SCALE}) ? t_q0 + 1'b1 : t_q0;
  assign h_q0    = h_prod[29:16];
  assign h_rem   = {1'b0, h_prod[15:0]} + {3'b000, h_q0};
  assign h_q     = (h_rem >= {1'b0, hsfd_pkg::FULL_SCALE}) ? h_q0 + 1'b1 : h_q0;
  assign t_shift = {1'b0, t_q} - hsfd_pkg::TEMP_OFFSET;

  always_ff @(posedge clk) begin
    if (s1_load) begin
      t_prod   <= 31'(frame.temperature_raw) * 31'(hsfd_pkg::TEMP_SPAN);
      h_prod   <= 30'(frame.humidity_raw) * 30'(hsfd_pkg::HUM_SPAN);
      s1_frame <= frame;
    end
    if (out_load) begin
      temperature_centi <= signed'(t_shift[14:0]);
      humidity_centi    <= h_q;
      temperature_raw   <= s1_frame.temperature_raw;
      humidity_raw      <= s1_frame.humidity_raw;
      status            <= s1_frame.status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= 1'b1;
      end else if (out_load) begin
        s1_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/hsfd_checker.sv =====
// Port-level checker for the humidity sensor frame decoder, bound to the top level.
module hsfd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // A stalled result keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("output item changed while stalled");

  // Humidity never exceeds one hundred percent.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[28:15] <= 14'd10000)
    else $error("humidity out of range");

  // Temperature stays within the sensor span.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ($signed(m_axis_tdata[14:0]) >= -15'sd4500)
      && ($signed(m_axis_tdata[14:0]) <= 15'sd13000))
    else $error("temperature out of range");

  // A full-scale humidity word and a zero temperature word map to the span ends.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[60:45] == 16'hFFFF) |-> m_axis_tdata[28:15] == 14'd10000)
    else $error("full-scale humidity not converted to 10000");

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[44:29] == 16'h0000)
      |-> $signed(m_axis_tdata[14:0]) == -15'sd4500)
    else $error("zero temperature word not converted to offset");

endmodule

bind humidity_sensor_frame_decoder hsfd_checker u_hsfd_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== test/tb.sv =====
// Self-checking testbench for the humidity sensor frame decoder: directed frames, then random traffic.
module tb;
  import hsfd_pkg::*;

  localparam int IDLE_PCT     = 14;
  localparam int N_ITEMS      = 2000;
  localparam int CALM_FROM    = 800;   // items in [CALM_FROM, CALM_TO) go with no idling
  localparam int CALM_TO      = 1100;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;

  // One decoded measurement, as it leaves the block.
  typedef struct packed {
    logic signed [14:0] temp_c;
    logic [13:0]        hum_c;
    logic [15:0]        temp_raw;
    logic [15:0]        hum_raw;
    logic               status;
  } reading_t;

  // One directed item, with an expectation typed in where it is obvious.
  typedef struct {
    logic [7:0] rx;
    logic       restart;
    logic       typed;
    reading_t   want;
  } stim_row_t;

  localparam reading_t ALL_ZERO_READING = '{temp_c: -4500, hum_c: 0, temp_raw: 16'h0000,
                                            hum_raw: 16'h0000, status: 1'b1};
  localparam reading_t ALL_ONES_READING = '{temp_c: 13000, hum_c: 10000, temp_raw: 16'hFFFF,
                                            hum_raw: 16'hFFFF, status: 1'b1};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tuser;

  // Typed expectation travelling alongside the item on the input side.
  logic        row_typed = 1'b0;
  reading_t    row_want = '0;
  logic        calm = 1'b0;

  int          n_sent = 0;
  int          n_bad = 0;
  int          quiet_cycles = 0;
  reading_t    readings_due[$];
  stim_row_t   stim[$];

  // Decoder state as the predictor sees it.
  pos_t        frame_pos = POS_T_HI;
  logic [7:0]  crc_acc = CRC_INIT;
  logic [15:0] t_word = '0;
  logic        t_good = 1'b0;
  logic [15:0] h_word = '0;

  humidity_sensor_frame_decoder uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bit-serial form of the sensor CRC: feedback is the top CRC bit against the data bit.
  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      c = {c[6:0], 1'b0} ^ ((c[7] ^ b[i]) ? CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  function automatic logic [7:0] word_check(input logic [15:0] w);
    return crc_step(crc_step(CRC_INIT, w[15:8]), w[7:0]);
  endfunction

  // Advances the frame state by one byte; returns 1 with the reading after a check byte of
  // the humidity word.
  function automatic bit decode_byte(input logic [7:0] b, input logic restart,
                                     output reading_t r);
    r = '0;
    case (restart ? POS_T_HI : frame_pos)
      POS_T_HI: begin
        crc_acc   = crc_step(CRC_INIT, b);
        t_word    = {b, 8'h00};
        frame_pos = POS_T_LO;
      end
      POS_T_LO: begin
        crc_acc     = crc_step(crc_acc, b);
        t_word[7:0] = b;
        frame_pos   = POS_T_CHK;
      end
      POS_T_CHK: begin
        t_good    = (crc_acc == b);
        crc_acc   = CRC_INIT;
        frame_pos = POS_H_HI;
      end
      POS_H_HI: begin
        crc_acc   = crc_step(CRC_INIT, b);
        h_word    = {b, 8'h00};
        frame_pos = POS_H_LO;
      end
      POS_H_LO: begin
        crc_acc     = crc_step(crc_acc, b);
        h_word[7:0] = b;
        frame_pos   = POS_H_CHK;
      end
      default: begin
        r.status   = !(t_good && crc_acc == b);
        r.temp_c   = 15'(-4500 + (17500 * int'(t_word)) / 65535);
        r.hum_c    = 14'((10000 * int'(h_word)) / 65535);
        r.temp_raw = t_word;
        r.hum_raw  = h_word;
        crc_acc    = CRC_INIT;
        frame_pos  = POS_T_HI;
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic void add_row(input logic [7:0] b, input logic restart,
                                  input logic typed = 1'b0, input reading_t want = '0);
    stim.push_back('{rx: b, restart: restart, typed: typed, want: want});
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offers one item, with random gaps outside the calm stretch, and waits for acceptance.
  task automatic send_byte(input logic [7:0] b, input logic restart,
                           input logic typed = 1'b0, input reading_t want = '0);
    logic quiet_now;
    quiet_now = (n_sent >= CALM_FROM && n_sent < CALM_TO);
    calm <= quiet_now;
    while (!quiet_now && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= restart;
    row_typed     <= typed;
    row_want      <= want;
    do @(posedge clk); while (!s_axis_tready);
    n_sent++;
  endtask

  // Well-formed frame with random words; a check byte is wrong now and then.
  task automatic send_frame(input logic restart);
    logic [15:0] tw, hw;
    logic [7:0]  tc, hc;
    tw = pick_word();
    hw = pick_word();
    tc = word_check(tw);
    hc = word_check(hw);
    if ($urandom_range(4) == 0) tc ^= 8'($urandom_range(1, 255));
    if ($urandom_range(4) == 0) hc ^= 8'($urandom_range(1, 255));
    send_byte(tw[15:8], restart);
    send_byte(tw[7:0], 1'b0);
    send_byte(tc, 1'b0);
    send_byte(hw[15:8], 1'b0);
    send_byte(hw[7:0], 1'b0);
    send_byte(hc, 1'b0);
  endtask

  task automatic field_check(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_bad++;
    end
  endtask

  always @(posedge clk) begin
    m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Predicts on every accepted byte, checks every accepted reading, and watches for a hang.
  always @(posedge clk) begin : monitor
    reading_t predicted, want, got;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (decode_byte(s_axis_tdata, s_axis_tuser, predicted)) begin
          readings_due.push_back(row_typed ? row_want : predicted);
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.temp_c   = m_axis_tdata[14:0];
        got.hum_c    = m_axis_tdata[28:15];
        got.temp_raw = m_axis_tdata[44:29];
        got.hum_raw  = m_axis_tdata[60:45];
        got.status   = m_axis_tuser;
        if (readings_due.size() == 0) begin
          $error("reading arrived with none expected: temperature_raw %0d", got.temp_raw);
          n_bad++;
        end else begin
          want = readings_due.pop_front();
          field_check("temperature_centi", want.temp_c, got.temp_c);
          field_check("humidity_centi", want.hum_c, got.hum_c);
          field_check("temperature_raw", want.temp_raw, got.temp_raw);
          field_check("humidity_raw", want.hum_raw, got.hum_raw);
          field_check("status", want.status, got.status);
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    logic need_restart;
    int   pick;
    int   len;

    // Both words at zero, both check bytes wrong; a restart on the very first byte.
    add_row(8'h00, 1'b1);
    add_row(8'h00, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h00, 1'b0, 1'b1, ALL_ZERO_READING);
    // Full scale on both words, check bytes wrong; follows with no restart.
    add_row(8'hFF, 1'b0);
    add_row(8'hFF, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'hFF, 1'b0);
    add_row(8'hFF, 1'b0);
    add_row(8'h00, 1'b0, 1'b1, ALL_ONES_READING);
    // Both checks good, restart on a byte that is the first one anyway.
    add_row(8'hBE, 1'b1);
    add_row(8'hEF, 1'b0);
    add_row(word_check(16'hBEEF), 1'b0);
    add_row(8'h80, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(word_check(16'h8000), 1'b0);
    // A partial frame dropped by a restart in the middle; humidity check wrong only.
    add_row(8'h12, 1'b0);
    add_row(8'h34, 1'b0);
    add_row(8'h66, 1'b1);
    add_row(8'h66, 1'b0);
    add_row(word_check(16'h6666), 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h01, 1'b0);
    add_row(word_check(16'h0001) ^ 8'h01, 1'b0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (stim[i]) begin
      send_byte(stim[i].rx, stim[i].restart, stim[i].typed, stim[i].want);
    end

    // Mostly whole frames; now and then a broken frame or a stray byte, after which the
    // next frame starts with a restart.
    need_restart = 1'b0;
    while (n_sent < N_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        len = $urandom_range(1, 5);
        for (int k = 0; k < len; k++) begin
          send_byte(8'($urandom), (k == 0) ? 1'($urandom) : 1'b0);
        end
        need_restart = 1'b1;
      end else if (pick < 12) begin
        send_byte(8'($urandom), 1'($urandom));
        need_restart = 1'b1;
      end else begin
        send_frame(need_restart || ($urandom_range(3) == 0));
        need_restart = 1'b0;
      end
    end
    s_axis_tvalid <= 1'b0;

    while (readings_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_bad == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
